>>> src/tmg_pkg.sv
// Shared types, widths, stage map and the constant log table for the tone map encoder.
package tmg_pkg;

    // field and register widths
    localparam int IN_W      = 32;
    localparam int GAIN_W    = 24;
    localparam int GAMMA_W   = 16;
    localparam int DISP_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    // channel datapath widths
    localparam int X_W       = 31;              // clamped channel, sign dropped
    localparam int NUM_W     = X_W + GAIN_W;    // x * exposure
    localparam int DEN_W     = NUM_W + 1;       // 2^(F+16) + num
    localparam int EXP_W     = 6;               // index of top set bit
    localparam int FRAC_W    = 32;              // log fraction bits, mantissa width
    localparam int LOG_W     = EXP_W + FRAC_W;
    localparam int GAMMA_FRAC = 12;
    localparam int EXPO_FRAC = 16;
    localparam int RHS_W     = LOG_W + GAMMA_FRAC;
    localparam int LOGK_W    = 35;              // log2 of an 8-bit code
    localparam int LHS_W     = GAMMA_W + LOGK_W;

    localparam logic [GAMMA_W-1:0] FALLBACK_GAMMA = 16'd9011;
    localparam logic [GAIN_W-1:0]  RESET_GAIN     = 24'd65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA   = 2'd2;

    // stage map of the pipeline
    localparam int LOG_STEPS = FRAC_W;
    localparam int SRCH_BITS = DISP_W;
    localparam int ST_IN     = 0;
    localparam int ST_DEN    = 1;
    localparam int ST_LZC    = 2;
    localparam int ST_NORM   = 3;
    localparam int ST_LOG0   = 4;
    localparam int ST_DIFF   = ST_LOG0 + LOG_STEPS;
    localparam int ST_SRCH0  = ST_DIFF + 1;
    localparam int ST_OUT    = ST_SRCH0 + 2 * SRCH_BITS;
    localparam int N_STAGE   = ST_OUT + 1;

    typedef enum logic [1:0] {
        SPEC_NORM,
        SPEC_ZERO,
        SPEC_FULL
    } t_spec;

    typedef struct packed {
        logic               tone_en;
        logic [GAIN_W-1:0]  gain;
        logic [GAMMA_W-1:0] gamma;
    } t_cfg;

    typedef logic [255:0][LOGK_W-1:0] t_log_tab;

    // fixed-point log2 with 32 fraction bits, by repeated squaring
    function automatic logic [LOGK_W-1:0] log2_const(input int unsigned k);
        logic [63:0]       m;
        logic [LOGK_W-1:0] r;
        int                e;
        e = 0;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (((k >> i) & 1) != 0) e = i;
        end
        if (k != 0) begin
            m = 64'(k) << (31 - e);
            r = LOGK_W'(e) << FRAC_W;
            for (int i = FRAC_W - 1; i >= 0; i--) begin
                m = (m * m) >> 31;
                if ((m >> 32) != 0) begin
                    m = m >> 1;
                    r[i] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic t_log_tab make_log_tab();
        t_log_tab t;
        for (int k = 0; k < 256; k++) t[k] = log2_const(k);
        return t;
    endfunction

    localparam t_log_tab          LOG_TAB = make_log_tab();
    localparam logic [LOGK_W-1:0] LOG_255 = LOG_TAB[255];

endpackage

>>> src/tone_map_gamma_encode.sv
// Top level: configuration registers, valid/ready pipeline control, three channels and alpha.
//
// Input channel: i_in_valid / o_in_ready carry one linear pixel (red, green, blue,
// alpha, signed fixed point with INPUT_FRAC_BITS fraction bits) per word.
// Output channel: o_out_valid / i_out_ready carry one 8-bit display pixel per word.
// Configuration: i_cfg_we writes register i_cfg_idx (0 tone enable, 1 exposure
// gain, 2 display gamma) from i_cfg_wdata; other indexes are dropped.
// Write only while no pixel is in flight.
// Throughput: one pixel per clock while the receiver takes output words. Pipeline
// of 54 stages: front end, 32 log squaring cells, a ratio stage, 8 two-stage
// search cells, output register.
// Each stage advances whenever it or any stage after it is empty, so bubbles
// close up and input is taken while a finished word waits at the output.
// When the receiver stalls with the pipeline full, o_in_ready drops.
// Reset (synchronous, active low) empties the pipeline and restores tone
// mapping on, unity exposure and gamma 2.2.
module tone_map_gamma_encode import tmg_pkg::*; #(
    parameter int INPUT_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [IN_W-1:0] i_linear_red,
    input  logic signed [IN_W-1:0] i_linear_green,
    input  logic signed [IN_W-1:0] i_linear_blue,
    input  logic signed [IN_W-1:0] i_linear_alpha,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DISP_W-1:0]    o_display_red,
    output logic [DISP_W-1:0]    o_display_green,
    output logic [DISP_W-1:0]    o_display_blue,
    output logic [DISP_W-1:0]    o_display_alpha
);

    localparam int A_W = INPUT_FRAC_BITS + 1;
    localparam int P_W = A_W + DISP_W;
    localparam logic [A_W-1:0] A_ONE = A_W'(1) << INPUT_FRAC_BITS;

    logic               r_tone_en;
    logic [GAIN_W-1:0]  r_gain;
    logic [GAMMA_W-1:0] r_gamma;
    t_cfg               w_cfg;

    logic [N_STAGE-1:0] r_vld;
    logic [N_STAGE-1:0] w_load;

    logic [A_W-1:0]     w_a;
    logic [P_W-1:0]     w_ap;
    logic [DISP_W-1:0]  r_alpha [0:N_STAGE-1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_en <= 1'b1;
            r_gain    <= RESET_GAIN;
            r_gamma   <= FALLBACK_GAMMA;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TONE_EN: r_tone_en <= i_cfg_wdata[0];
                CFG_GAIN:    r_gain    <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAMMA:   r_gamma   <= i_cfg_wdata[GAMMA_W-1:0];
                default:     r_tone_en <= r_tone_en;
            endcase
        end
    end

    always_comb begin
        w_cfg.tone_en = r_tone_en;
        w_cfg.gain    = r_gain;
        w_cfg.gamma   = (r_gamma == '0) ? FALLBACK_GAMMA : r_gamma;
    end

    // a stage advances when it or any later stage has a hole, or the output drains
    for (genvar k = 0; k < N_STAGE; k++) begin : g_load
        assign w_load[k] = i_out_ready || !(&r_vld[N_STAGE-1:k]);
    end

    assign o_in_ready  = w_load[ST_IN];
    assign o_out_valid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_load[ST_IN]) r_vld[ST_IN] <= i_in_valid;
            for (int k = 1; k < N_STAGE; k++) begin
                if (w_load[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // alpha: clamp to [0,1] and scale by 255
    always_comb begin
        if (i_linear_alpha[IN_W-1]) begin
            w_a = '0;
        end else if (IN_W'(i_linear_alpha) > IN_W'(A_ONE)) begin
            w_a = A_ONE;
        end else begin
            w_a = i_linear_alpha[A_W-1:0];
        end
        w_ap = (P_W'(w_a) << DISP_W) - P_W'(w_a);
    end

    always_ff @(posedge i_clk) begin
        if (w_load[ST_IN]) r_alpha[ST_IN] <= w_ap[P_W-2:INPUT_FRAC_BITS];
    end

    for (genvar k = 1; k < N_STAGE; k++) begin : g_alpha
        always_ff @(posedge i_clk) begin
            if (w_load[k]) r_alpha[k] <= r_alpha[k-1];
        end
    end

    assign o_display_alpha = r_alpha[ST_OUT];

    // colour channels
    tmg_channel #(.INPUT_FRAC_BITS(INPUT_FRAC_BITS)) u_red (
        .i_clk     (i_clk),
        .i_load    (w_load),
        .i_cfg     (w_cfg),
        .i_linear  (i_linear_red),
        .o_display (o_display_red)
    );

    tmg_channel #(.INPUT_FRAC_BITS(INPUT_FRAC_BITS)) u_green (
        .i_clk     (i_clk),
        .i_load    (w_load),
        .i_cfg     (w_cfg),
        .i_linear  (i_linear_green),
        .o_display (o_display_green)
    );

    tmg_channel #(.INPUT_FRAC_BITS(INPUT_FRAC_BITS)) u_blue (
        .i_clk     (i_clk),
        .i_load    (w_load),
        .i_cfg     (w_cfg),
        .i_linear  (i_linear_blue),
        .o_display (o_display_blue)
    );

endmodule

>>> src/tmg_log_cell.sv
// One squaring step of the log2 chain: produces one fraction bit per cell.
module tmg_log_cell import tmg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [FRAC_W-1:0] i_m,
    input  logic [EXP_W-1:0]  i_exp,
    input  logic [FRAC_W-1:0] i_frac,
    output logic [FRAC_W-1:0] o_m,
    output logic [EXP_W-1:0]  o_exp,
    output logic [FRAC_W-1:0] o_frac
);

    logic [2*FRAC_W-1:0] w_sq;
    logic [FRAC_W:0]     w_sh;
    logic [FRAC_W-1:0]   n_m;
    logic                w_bit;

    // square the mantissa and renormalize
    always_comb begin
        w_sq  = (2*FRAC_W)'(i_m) * (2*FRAC_W)'(i_m);
        w_sh  = w_sq[2*FRAC_W-1:FRAC_W-1];
        w_bit = w_sh[FRAC_W];
        n_m   = w_bit ? w_sh[FRAC_W:1] : w_sh[FRAC_W-1:0];
    end

    // hold the partial log for the next cell
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_m    <= n_m;
            o_exp  <= i_exp;
            o_frac <= {i_frac[FRAC_W-2:0], w_bit};
        end
    end

endmodule

>>> src/tmg_search_cell.sv
// One bit of the output code search: multiply stage, then compare stage.
module tmg_search_cell import tmg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_load_a,
    input  logic               i_load_b,
    input  logic [GAMMA_W-1:0] i_gamma,
    input  logic [DISP_W-1:0]  i_lo,
    input  logic [DISP_W-1:0]  i_mask,
    input  logic [RHS_W-1:0]   i_rhs,
    output logic [DISP_W-1:0]  o_lo,
    output logic [DISP_W-1:0]  o_mask,
    output logic [RHS_W-1:0]   o_rhs
);

    logic [DISP_W-1:0] w_cand;
    logic [LOGK_W-1:0] w_diff;
    logic [DISP_W-1:0] r_cand;
    logic [DISP_W-1:0] r_lo_a;
    logic [DISP_W-1:0] r_mask_a;
    logic [RHS_W-1:0]  r_rhs_a;
    logic [LHS_W-1:0]  r_lhs;

    // weigh the candidate code in the log domain
    always_comb begin
        w_cand = i_lo | i_mask;
        w_diff = LOG_255 - LOG_TAB[w_cand];
    end

    always_ff @(posedge i_clk) begin
        if (i_load_a) begin
            r_cand   <= w_cand;
            r_lo_a   <= i_lo;
            r_mask_a <= i_mask >> 1;
            r_rhs_a  <= i_rhs;
            r_lhs    <= LHS_W'(i_gamma) * LHS_W'(w_diff);
        end
    end

    // keep the candidate when its power stays at or below the target
    always_ff @(posedge i_clk) begin
        if (i_load_b) begin
            o_lo   <= (r_lhs >= LHS_W'(r_rhs_a)) ? r_cand : r_lo_a;
            o_mask <= r_mask_a;
            o_rhs  <= r_rhs_a;
        end
    end

endmodule

>>> src/tmg_channel.sv
// One colour channel: exposure, Reinhard fraction, two log chains and the code search.
module tmg_channel import tmg_pkg::*; #(
    parameter int INPUT_FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic [N_STAGE-1:0] i_load,
    input  t_cfg              i_cfg,
    input  logic [IN_W-1:0]   i_linear,
    output logic [DISP_W-1:0] o_display
);

    localparam logic [NUM_W-1:0] ONE      = NUM_W'(1) << INPUT_FRAC_BITS;
    localparam logic [DEN_W-1:0] DEN_BASE = DEN_W'(1) << (INPUT_FRAC_BITS + EXPO_FRAC);
    localparam logic [EXP_W-1:0] NORM_TOP = EXP_W'(DEN_W - 1);

    logic [X_W-1:0]    w_x;
    logic [NUM_W-1:0]  n_num;
    logic [NUM_W-1:0]  r_num0;
    logic [NUM_W-1:0]  r_num1;
    logic [DEN_W-1:0]  r_den1;
    logic [DEN_W-1:0]  n_den;
    logic [NUM_W-1:0]  r_num2;
    logic [DEN_W-1:0]  r_den2;
    logic [EXP_W-1:0]  r_en2;
    logic [EXP_W-1:0]  r_ed2;
    logic [EXP_W-1:0]  n_en;
    logic [EXP_W-1:0]  n_ed;
    logic [DEN_W-1:0]  w_ljn;
    logic [DEN_W-1:0]  w_ljd;
    logic [FRAC_W-1:0] r_mn;
    logic [FRAC_W-1:0] r_md;
    logic [EXP_W-1:0]  r_en3;
    logic [EXP_W-1:0]  r_ed3;
    t_spec             n_spec;
    t_spec             r_spec [ST_DEN:ST_OUT-1];
    logic [RHS_W-1:0]  r_rhs;
    logic [DISP_W-1:0] r_disp;

    logic [FRAC_W-1:0] w_mn [0:LOG_STEPS];
    logic [EXP_W-1:0]  w_en [0:LOG_STEPS];
    logic [FRAC_W-1:0] w_fn [0:LOG_STEPS];
    logic [FRAC_W-1:0] w_md [0:LOG_STEPS];
    logic [EXP_W-1:0]  w_ed [0:LOG_STEPS];
    logic [FRAC_W-1:0] w_fd [0:LOG_STEPS];

    logic [DISP_W-1:0] w_lo   [0:SRCH_BITS];
    logic [DISP_W-1:0] w_mask [0:SRCH_BITS];
    logic [RHS_W-1:0]  w_rhs  [0:SRCH_BITS];

    // clamp negative, then scale by exposure or clip to one
    always_comb begin
        w_x = i_linear[IN_W-1] ? '0 : i_linear[X_W-1:0];
        if (i_cfg.tone_en) begin
            n_num = NUM_W'(w_x) * NUM_W'(i_cfg.gain);
        end else begin
            n_num = (NUM_W'(w_x) > ONE) ? ONE : NUM_W'(w_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[ST_IN]) r_num0 <= n_num;
    end

    // form the denominator and flag the saturated cases
    always_comb begin
        n_den = i_cfg.tone_en ? (DEN_BASE + DEN_W'(r_num0)) : DEN_W'(ONE);
        if (r_num0 == '0) begin
            n_spec = SPEC_ZERO;
        end else if (DEN_W'(r_num0) >= n_den) begin
            n_spec = SPEC_FULL;
        end else begin
            n_spec = SPEC_NORM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[ST_DEN]) begin
            r_num1         <= r_num0;
            r_den1         <= n_den;
            r_spec[ST_DEN] <= n_spec;
        end
    end

    // find the top set bit of both operands
    always_comb begin
        n_en = '0;
        n_ed = '0;
        for (int i = 0; i < NUM_W; i++) begin
            if (r_num1[i]) n_en = EXP_W'(i);
        end
        for (int i = 0; i < DEN_W; i++) begin
            if (r_den1[i]) n_ed = EXP_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[ST_LZC]) begin
            r_num2 <= r_num1;
            r_den2 <= r_den1;
            r_en2  <= n_en;
            r_ed2  <= n_ed;
        end
    end

    // left-justify and keep the top 32 bits as mantissa
    always_comb begin
        w_ljn = DEN_W'(r_num2) << (NORM_TOP - r_en2);
        w_ljd = r_den2 << (NORM_TOP - r_ed2);
    end

    always_ff @(posedge i_clk) begin
        if (i_load[ST_NORM]) begin
            r_mn  <= w_ljn[DEN_W-1:DEN_W-FRAC_W];
            r_md  <= w_ljd[DEN_W-1:DEN_W-FRAC_W];
            r_en3 <= r_en2;
            r_ed3 <= r_ed2;
        end
    end

    assign w_mn[0] = r_mn;
    assign w_en[0] = r_en3;
    assign w_fn[0] = '0;
    assign w_md[0] = r_md;
    assign w_ed[0] = r_ed3;
    assign w_fd[0] = '0;

    // log chains for numerator and denominator
    for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
        tmg_log_cell u_num (
            .i_clk  (i_clk),
            .i_load (i_load[ST_LOG0+j]),
            .i_m    (w_mn[j]),
            .i_exp  (w_en[j]),
            .i_frac (w_fn[j]),
            .o_m    (w_mn[j+1]),
            .o_exp  (w_en[j+1]),
            .o_frac (w_fn[j+1])
        );
        tmg_log_cell u_den (
            .i_clk  (i_clk),
            .i_load (i_load[ST_LOG0+j]),
            .i_m    (w_md[j]),
            .i_exp  (w_ed[j]),
            .i_frac (w_fd[j]),
            .o_m    (w_md[j+1]),
            .o_exp  (w_ed[j+1]),
            .o_frac (w_fd[j+1])
        );
    end

    // scale the log ratio by the gamma unit
    always_ff @(posedge i_clk) begin
        if (i_load[ST_DIFF]) begin
            r_rhs <= RHS_W'({w_ed[LOG_STEPS], w_fd[LOG_STEPS]}
                            - {w_en[LOG_STEPS], w_fn[LOG_STEPS]}) << GAMMA_FRAC;
        end
    end

    assign w_lo[0]   = '0;
    assign w_mask[0] = DISP_W'(1) << (DISP_W - 1);
    assign w_rhs[0]  = r_rhs;

    // binary search for the largest code, most significant bit first
    for (genvar j = 0; j < SRCH_BITS; j++) begin : g_srch
        tmg_search_cell u_bit (
            .i_clk    (i_clk),
            .i_load_a (i_load[ST_SRCH0+2*j]),
            .i_load_b (i_load[ST_SRCH0+2*j+1]),
            .i_gamma  (i_cfg.gamma),
            .i_lo     (w_lo[j]),
            .i_mask   (w_mask[j]),
            .i_rhs    (w_rhs[j]),
            .o_lo     (w_lo[j+1]),
            .o_mask   (w_mask[j+1]),
            .o_rhs    (w_rhs[j+1])
        );
    end

    // carry the saturation flag alongside
    for (genvar k = ST_DEN + 1; k < ST_OUT; k++) begin : g_spec
        always_ff @(posedge i_clk) begin
            if (i_load[k]) r_spec[k] <= r_spec[k-1];
        end
    end

    // pick the final code
    always_ff @(posedge i_clk) begin
        if (i_load[ST_OUT]) begin
            unique case (r_spec[ST_OUT-1])
                SPEC_ZERO: r_disp <= '0;
                SPEC_FULL: r_disp <= '1;
                SPEC_NORM: r_disp <= w_lo[SRCH_BITS];
                default:   r_disp <= '0;
            endcase
        end
    end

    assign o_display = r_disp;

endmodule

>>> src/tmg_checker.sv
// Port-level checks for the tone map encoder, bound to the top level.
module tmg_checker import tmg_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [DISP_W-1:0] o_display_red,
    input logic [DISP_W-1:0] o_display_green,
    input logic [DISP_W-1:0] o_display_blue,
    input logic [DISP_W-1:0] o_display_alpha
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word present after reset");

    // an empty output slot means every stage can take a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // a draining output lets the whole pipeline advance
    a_ready_when_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |-> o_in_ready)
        else $error("input stalled while output drains");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_display_red)
            && $stable(o_display_green) && $stable(o_display_blue)
            && $stable(o_display_alpha))
        else $error("stalled output word changed");

endmodule

bind tone_map_gamma_encode tmg_checker u_tmg_checker (.*);

>>> tb/sv/tb_tone_map_gamma_encode.sv
// Testbench for tone_map_gamma_encode: random and directed pixels checked against a predictor.
`timescale 1ns / 1ps

module tb_tone_map_gamma_encode;
    import tmg_pkg::*;

    localparam int FB = 16;
    localparam int N_RANDOM = 1900;
    localparam int WATCHDOG_MAX = 5000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic signed [IN_W-1:0] red;
        logic signed [IN_W-1:0] green;
        logic signed [IN_W-1:0] blue;
        logic signed [IN_W-1:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic [DISP_W-1:0] red;
        logic [DISP_W-1:0] green;
        logic [DISP_W-1:0] blue;
        logic [DISP_W-1:0] alpha;
    } t_disp;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [IN_W-1:0] i_linear_red, i_linear_green, i_linear_blue, i_linear_alpha;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [DISP_W-1:0]    o_display_red, o_display_green, o_display_blue, o_display_alpha;

    tone_map_gamma_encode #(.INPUT_FRAC_BITS(FB)) DUT (.*);

    // model copy of the registers
    logic               tone_on;
    logic [GAIN_W-1:0]  gain_reg;
    logic [GAMMA_W-1:0] gamma_reg;

    t_pixel pending_pixels[$];
    t_disp  expected_pixels[$];
    int     mismatches;
    int     watchdog;
    bit     timed_out;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // log2 with 32 fraction bits by repeated squaring
    function automatic logic [63:0] log2_fixed(input logic [63:0] n);
        logic [63:0] m;
        logic [63:0] r;
        int          e;
        e = 0;
        r = '0;
        if (n == 0) return '0;
        for (int i = 0; i < 64; i++) if (n[i]) e = i;
        m = (e >= 31) ? (n >> (e - 31)) : (n << (31 - e));
        r = 64'(e) << 32;
        for (int i = 31; i >= 0; i--) begin
            m = (m * m) >> 31;
            if ((m >> 32) != 0) begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] gamma_code(input logic [63:0] num, input logic [63:0] den,
                                              input logic [63:0] g);
        logic [63:0] rhs, l255, lhs;
        logic [7:0]  lo, cand;
        if (num == 0) return 8'd0;
        if (num >= den) return 8'd255;
        rhs  = (log2_fixed(den) - log2_fixed(num)) << GAMMA_FRAC;
        l255 = log2_fixed(64'd255);
        lo   = '0;
        for (int b = 7; b >= 0; b--) begin
            cand = lo;
            cand[b] = 1'b1;
            lhs = g * (l255 - log2_fixed(64'(cand)));
            if (lhs >= rhs) lo = cand;
        end
        return lo;
    endfunction

    function automatic logic [7:0] encode_color(input logic signed [IN_W-1:0] raw,
                                                input logic [63:0] g);
        logic [63:0] x, num, den;
        x = raw[IN_W-1] ? 64'd0 : 64'(raw);
        if (tone_on) begin
            num = x * 64'(gain_reg);
            den = (64'd1 << (FB + 16)) + num;
        end else begin
            num = (x > (64'd1 << FB)) ? (64'd1 << FB) : x;
            den = 64'd1 << FB;
        end
        return gamma_code(num, den, g);
    endfunction

    function automatic t_disp predict_display(input t_pixel p);
        t_disp       d;
        logic [63:0] g, a;
        g = (gamma_reg == 0) ? 64'(FALLBACK_GAMMA) : 64'(gamma_reg);
        d.red   = encode_color(p.red, g);
        d.green = encode_color(p.green, g);
        d.blue  = encode_color(p.blue, g);
        a = p.alpha[IN_W-1] ? 64'd0 : 64'(p.alpha);
        if (a > (64'd1 << FB)) a = 64'd1 << FB;
        d.alpha = 8'((a * 255) >> FB);
        return d;
    endfunction

    // ready sampled at the rising edge tells the driver a word was taken
    logic o_in_ready_q;
    always @(posedge i_clk) o_in_ready_q <= o_in_ready & i_in_valid;

    // drive pixels from the pending queue with random gaps
    int     in_gap;
    t_pixel cur_pixel;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready_q) begin
                expected_pixels.push_back(predict_display(cur_pixel));
                in_gap = $urandom_range(0, 6);
                if ($urandom_range(0, 3) == 0) in_gap = 0;
            end
            if (!i_in_valid || o_in_ready_q) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    cur_pixel = pending_pixels.pop_front();
                    i_linear_red   <= cur_pixel.red;
                    i_linear_green <= cur_pixel.green;
                    i_linear_blue  <= cur_pixel.blue;
                    i_linear_alpha <= cur_pixel.alpha;
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls and result check
    int out_gap;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 7) == 0) out_gap = $urandom_range(0, 6);
            end
        end
    end

    always @(posedge i_clk) begin
        t_disp got, want;
        if (!i_rst_n) begin
            watchdog <= 0;
        end else begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) watchdog <= 0;
            else watchdog <= watchdog + 1;
            if (o_out_valid && i_out_ready) begin
                got = {o_display_red, o_display_green, o_display_blue, o_display_alpha};
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", got);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected r%0d g%0d b%0d a%0d got r%0d g%0d b%0d a%0d",
                                     want.red, want.green, want.blue, want.alpha,
                                     got.red, got.green, got.blue, got.alpha);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (watchdog >= WATCHDOG_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic signed [IN_W-1:0] rand_channel();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0001_0000);
            2: return $urandom_range(0, 32'h0000_0400);
            3: return $urandom_range(0, 32'h0010_0000);
            4: return -$signed({1'b0, 31'($urandom_range(0, 32'h0002_0000))});
            default: return $urandom_range(32'h0000_8000, 32'h0003_0000);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TONE_EN: tone_on   = val[0];
            CFG_GAIN:    gain_reg  = val[GAIN_W-1:0];
            CFG_GAMMA:   gamma_reg = val[GAMMA_W-1:0];
            default: ;
        endcase
    endtask

    // hold until every queued pixel is checked, then let the pipeline drain
    task automatic wait_idle();
        while (pending_pixels.size() > 0 || i_in_valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_pixel(input logic signed [IN_W-1:0] r, g, b, a);
        pending_pixels.push_back({r, g, b, a});
    endtask

    initial begin
        t_pixel p;
        int     phase_items;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_TONE_EN;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_linear_red = '0;
        i_linear_green = '0;
        i_linear_blue = '0;
        i_linear_alpha = '0;
        tone_on = 1'b1;
        gain_reg = RESET_GAIN;
        gamma_reg = FALLBACK_GAMMA;
        mismatches = 0;
        watchdog = 0;
        timed_out = 1'b0;
        in_gap = 0;
        out_gap = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, negatives, unity, alpha limits with reset settings
        push_pixel(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh7FFF_FFFF);
        push_pixel(0, 1, 32'sh0001_0000, 32'sh8000_0000);
        push_pixel(32'sh0000_FFFF, 32'sh0001_0001, -1, 32'sh0001_0000);
        push_pixel(32'sh0000_8000, 32'sh0000_0100, 32'sh0010_0000, 32'sh0000_FFFF);
        push_pixel(-1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_8000);
        wait_idle();

        // tone off, gamma zero (falls back), index beyond list dropped
        write_reg(CFG_TONE_EN, 24'hFFFFFE);
        write_reg(CFG_GAMMA, 24'hFF0000);
        write_reg(2'd3, 24'h123456);
        push_pixel(32'sh0001_0000, 32'sh0000_FFFF, 1, 32'sh0000_0001);
        push_pixel(32'sh0000_4000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0002_0000);
        push_pixel(32'sh0000_0002, 32'sh0000_1000, 32'sh0000_C000, 32'sh0000_4000);
        wait_idle();

        // tone on with zero exposure, then maximum exposure and extreme gammas
        write_reg(CFG_TONE_EN, 24'd1);
        write_reg(CFG_GAIN, 24'd0);
        push_pixel(32'sh7FFF_FFFF, 32'sh0001_0000, 5, 32'sh0000_0000);
        wait_idle();
        write_reg(CFG_GAIN, 24'hFFFFFF);
        write_reg(CFG_GAMMA, 24'h00FFFF);
        push_pixel(1, 32'sh0000_0010, 32'sh7FFF_FFFF, 32'sh0000_0001);
        push_pixel(32'sh0000_0100, 0, 32'sh0000_0003, 32'sh7FFF_FFFF);
        wait_idle();
        write_reg(CFG_GAMMA, 24'd1);
        write_reg(CFG_GAIN, 24'd1);
        push_pixel(1, 32'sh0001_0000, 32'sh7FFF_FFFF, 32'sh0000_0001);
        push_pixel(32'sh0000_0100, 32'sh0000_8000, 32'sh0100_0000, 32'sh0000_C000);
        wait_idle();

        // random phases, each with fresh settings
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_TONE_EN, CFG_DAT_W'($urandom()));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_GAIN, CFG_DAT_W'($urandom()));
                1: write_reg(CFG_GAIN, CFG_DAT_W'($urandom_range(0, 24'h040000)));
                2: write_reg(CFG_GAIN, 24'h010000);
                default: write_reg(CFG_GAIN, 24'hFFFFFF);
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(CFG_GAMMA, 24'd0);
                1: write_reg(CFG_GAMMA, CFG_DAT_W'($urandom()));
                default: write_reg(CFG_GAMMA, CFG_DAT_W'($urandom_range(2048, 16384)));
            endcase
            phase_items = N_RANDOM / 10;
            for (int k = 0; k < phase_items; k++) begin
                p.red   = rand_channel();
                p.green = rand_channel();
                p.blue  = rand_channel();
                p.alpha = rand_channel();
                pending_pixels.push_back(p);
            end
            wait_idle();
        end

        if (mismatches == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
